[hw/rtl/tmf_pkg.sv]
// Shared constants and types for the trimmed mean filter.
package tmf_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_W    = 32;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int VAL_W       = SAMPLE_W + 1;
   localparam int SUM_W       = VAL_W + $clog2(MAX_SAMPLES);
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int REM_W       = CNT_W + 1;
   localparam int REQ_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SAMPLE_W + CNT_W + 7) / 8) * 8;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic signed [VAL_W-1:0] largest;
      logic signed [VAL_W-1:0] smallest;
      logic [CNT_W-1:0]        count;
      logic                    saturated;
   } tmf_stats_type;

endpackage

[hw/rtl/tmf_accum.sv]
// Per-set running sum, maximum, minimum and saturating sample count.
module tmf_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         sample_valid,
   input  logic [tmf_pkg::SAMPLE_W-1:0] sample,
   input  logic                         signed_mode,
   input  logic                         clear,
   output tmf_pkg::tmf_stats_type       stats
);
   import tmf_pkg::*;

   tmf_stats_type           stats_ff;
   tmf_stats_type           stats_in;
   logic signed [VAL_W-1:0] value;
   logic                    full;

   // widen per the mode in force for this sample
   assign value = {signed_mode & sample[SAMPLE_W-1], sample};
   assign full  = (stats_ff.count >= CNT_W'(MAX_SAMPLES));

   always_comb begin
      stats_in = stats_ff;
      if (clear) begin
         stats_in = '0;
      end else if (sample_valid) begin
         if (full) begin
            stats_in.saturated = 1'b1;
         end else begin
            if (stats_ff.count == '0) begin
               stats_in.largest  = value;
               stats_in.smallest = value;
            end else begin
               if (value > stats_ff.largest) begin
                  stats_in.largest = value;
               end
               if (value < stats_ff.smallest) begin
                  stats_in.smallest = value;
               end
            end
            stats_in.sum   = stats_ff.sum + SUM_W'(value);
            stats_in.count = stats_ff.count + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign stats = stats_ff;

endmodule

[hw/rtl/tmf_divider.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module tmf_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tmf_pkg::SUM_W-1:0]    dividend,
   input  logic [tmf_pkg::CNT_W-1:0]           divisor,
   input  logic                                take,
   output logic                                done,
   output logic [tmf_pkg::SAMPLE_W-1:0]        quotient
);
   import tmf_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    den_ff, den_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic [REM_W-1:0]    shifted;
   logic [REM_W-1:0]    diff;
   logic                fits;

   assign shifted = {rem_ff, num_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (take) begin
         done_in = 1'b0;
      end
      if (start) begin
         // work on the magnitude, fix the sign at the end
         neg_in  = dividend[SUM_W-1];
         num_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = '0;
         step_in = STEP_W'(SUM_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[SUM_W-2:0], 1'b0};
         rem_in = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SAMPLE_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (-quo_ff) : quo_ff;

endmodule

[hw/rtl/trimmed_mean_filter.sv]
// Trimmed mean filter: averages a set of samples with largest and smallest dropped.
// Throughput: one sample request per cycle inside a set; after a closing sample,
//   requests are held off while the set closes and, for a set of three or more
//   samples, while the bit-serial divider runs and until the output stage is free.
// Sets of two or fewer samples give no result; others pass ST_START and ST_DIVIDE.
// Reset: synchronous, active high; clears set state, signed mode and output valid.
module trimmed_mean_filter (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = sample[31:0]; tlast = last
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tmf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   // result: tdata = mean[31:0], sample_count[42:32], zero fill; tuser = overflow
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tmf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   // configuration: signed_mode
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);
   import tmf_pkg::*;

   typedef enum logic [3:0] {
      ST_ACCUM  = 4'b0001,
      ST_CLOSE  = 4'b0010,
      ST_START  = 4'b0100,
      ST_DIVIDE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic                    signed_mode_ff;
   logic                    req_accept;
   logic                    acc_clear;
   tmf_stats_type           stats;
   logic signed [SUM_W-1:0] trimmed_ff, trimmed_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    sat_ff, sat_in;
   logic                    div_start;
   logic                    div_take;
   logic                    div_done;
   logic [SAMPLE_W-1:0]     div_quotient;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_mean_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_over_ff;
   logic                    rsp_free;

   assign req_tready = (state_ff == ST_ACCUM);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // mode register; user must write only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         signed_mode_ff <= csr_wr_data;
      end
   end

   tmf_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .sample_valid(req_accept),
      .sample      (req_tdata[SAMPLE_W-1:0]),
      .signed_mode (signed_mode_ff),
      .clear       (acc_clear),
      .stats       (stats)
   );

   tmf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(trimmed_ff),
      .divisor (count_ff),
      .take    (div_take),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // sequencer: accumulate, close the set, run the divider, hand off the result
   always_comb begin
      state_in     = state_ff;
      acc_clear    = 1'b0;
      div_start    = 1'b0;
      div_take     = 1'b0;
      trimmed_in   = trimmed_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_accept && req_tlast) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            // stats now include the closing sample; drop short sets
            acc_clear = 1'b1;
            if (stats.count <= CNT_W'(2)) begin
               state_in = ST_ACCUM;
            end else begin
               trimmed_in = stats.sum - SUM_W'(stats.largest) - SUM_W'(stats.smallest);
               count_in   = stats.count;
               sat_in     = stats.saturated;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // hold the quotient in the divider until the output stage is free
            if (div_done && rsp_free) begin
               div_take     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trimmed_ff <= trimmed_in;
      // divisor is count - 2; the result adds 2 back for the count
      if (state_ff == ST_CLOSE) begin
         count_ff <= count_in - CNT_W'(2);
      end
      sat_ff <= sat_in;
      if (div_take) begin
         rsp_mean_ff  <= div_quotient;
         rsp_count_ff <= count_ff + CNT_W'(2);
         rsp_over_ff  <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_mean_ff});
   assign rsp_tuser  = rsp_over_ff;

endmodule
